@@ src/plid_pkg.sv @@
`timescale 1ns / 1ps

package plid_pkg;

  localparam int DATA_W    = 32;
  localparam int POS_W     = 6;
  localparam int LEN_W     = 7;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } plid_cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } plid_status_t;

  // Broadcast to every cell of the row for one request.
  typedef struct packed {
    logic ins;
    logic del;
    logic rd;
  } plid_op_t;

endpackage

@@ src/plid_cell.sv @@
`timescale 1ns / 1ps

module plid_cell import plid_pkg::*; #(
  parameter int IDX_W = 6,
  parameter int IDX   = 0
) (
  input  logic                     clk,
  input  plid_op_t                 op,
  input  logic [IDX_W-1:0]         slot,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic signed [DATA_W-1:0] right_value,
  output logic signed [DATA_W-1:0] value,
  output logic signed [DATA_W-1:0] rd_tap
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic signed [DATA_W-1:0] val_r;
  logic signed [DATA_W-1:0] val_nxt;

  // Insert shifts cells above the slot up by one; delete pulls cells from the
  // slot upward down by one. Cells below the slot keep their value.
  always_comb begin
    val_nxt = val_r;
    if (op.ins) begin
      if (MY_IDX > slot) begin
        val_nxt = left_value;
      end else if (MY_IDX == slot) begin
        val_nxt = new_value;
      end
    end else if (op.del && (MY_IDX >= slot)) begin
      val_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign value  = val_r;
  assign rd_tap = (op.rd && (MY_IDX == slot)) ? val_r : '0;

endmodule

@@ src/positional_list_insert_delete_top.sv @@
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_ready   in_command, in_position, in_new_value
// out_     output     out_valid / out_ready out_status, out_length, out_read_value
//
// One request per cycle unless an unread result is held: the whole cell row shifts
// when a request is accepted; its result is in the output register the next cycle.
// Reset (rst_n low, synchronous) clears the element count and output valid;
// cell contents are not cleared and are only read below the count.
// in_ready is low during reset and while a result sits in the output register unread.

module positional_list_insert_delete_top import plid_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [CMD_W-1:0]           in_command,
  input  logic [POS_W-1:0]           in_position,
  input  logic signed [DATA_W-1:0]   in_new_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        out_status,
  output logic [LEN_W-1:0]           out_length,
  output logic signed [DATA_W-1:0]   out_read_value
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      out_valid_r;
  plid_status_t              status_r, status_nxt;
  logic [LEN_W-1:0]          length_r;
  logic signed [DATA_W-1:0]  rdval_r, rdval_nxt;

  logic                      acc;
  plid_cmd_t                 cmd;
  logic [CMP_W-1:0]          pos_c, cnt_c;
  logic                      append, full, in_range;
  plid_op_t                  op;
  logic [IDX_W-1:0]          slot;

  logic signed [DATA_W-1:0]  cell_val [CAPACITY];
  logic signed [DATA_W-1:0]  cell_tap [CAPACITY];
  logic signed [DATA_W-1:0]  rd_any;

  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign acc      = in_valid && in_ready;
  assign cmd      = plid_cmd_t'(in_command);

  assign pos_c    = CMP_W'(in_position);
  assign cnt_c    = CMP_W'(count_r);
  assign append   = (cnt_c == '0) || ((pos_c + 1'b1) == cnt_c);
  assign full     = (cnt_c >= CAP_C);
  assign in_range = (pos_c < cnt_c);

  always_comb begin
    status_nxt = ST_OK;
    op         = '0;
    slot       = IDX_W'(pos_c);
    count_nxt  = count_r;
    unique case (cmd)
      CMD_INSERT: begin
        priority if (append) begin
          slot = IDX_W'(cnt_c);
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            op.ins = acc;
          end
        end else if (!in_range) begin
          status_nxt = ST_RANGE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          slot   = IDX_W'(pos_c + 1'b1);
          op.ins = acc;
        end
        if (op.ins) begin
          count_nxt = count_r + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else begin
          op.del    = acc;
          count_nxt = acc ? count_r - 1'b1 : count_r;
        end
      end
      CMD_READ: begin
        if (!in_range) begin
          status_nxt = ST_RANGE;
        end else begin
          op.rd = 1'b1;
        end
      end
      default: ;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = in_new_value;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[i];
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end
    plid_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk         (clk),
      .op          (op),
      .slot        (slot),
      .new_value   (in_new_value),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_val[i]),
      .rd_tap      (cell_tap[i])
    );
  end

  // At most one cell drives a nonzero tap.
  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | cell_tap[i];
    end
  end

  assign rdval_nxt = op.rd ? rd_any : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_r <= status_nxt;
      length_r <= LEN_W'(count_nxt);
      rdval_r  <= rdval_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_length     = length_r;
  assign out_read_value = rdval_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CAP_C)
    else $error("element count above capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    op.ins |=> count_r == CNT_W'($past(count_r) + 1'b1))
    else $error("insert did not grow the list");

  a_del_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    op.del |=> count_r == CNT_W'($past(count_r) - 1'b1))
    else $error("delete did not shrink the list");

  a_err_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && status_nxt != ST_OK) |=> ($stable(count_r) && rdval_r == '0))
    else $error("failed request changed state or returned data");

  a_len_matches: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_length == LEN_W'(count_r))
    else $error("reported length differs from count");

endmodule

@@ bench/positional_list_insert_delete_top_tb.sv @@
`timescale 1ns / 1ps

module positional_list_insert_delete_top_tb;
  import plid_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RAND_BLOCKS = 6;
  localparam int BLOCK_ITEMS = 60;
  localparam int DIR_ROWS    = 26;

  typedef struct packed {
    plid_status_t               status;
    logic [LEN_W-1:0]           length;
    logic signed [DATA_W-1:0]   read_value;
  } list_result_t;

  typedef struct {
    bit                 fill;    // fill the list to capacity before this request
    plid_cmd_t          cmd;
    logic [POS_W-1:0]   pos;
    logic [DATA_W-1:0]  val;
    bit                 pinned;  // expected result typed in below
    plid_status_t       st;
    logic [LEN_W-1:0]   len;
    logic [DATA_W-1:0]  rd;
  } dir_row_t;

  logic                      clk;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [CMD_W-1:0]          in_command = '0;
  logic [POS_W-1:0]          in_position = '0;
  logic signed [DATA_W-1:0]  in_new_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [STATUS_W-1:0]       out_status;
  logic [LEN_W-1:0]          out_length;
  logic signed [DATA_W-1:0]  out_read_value;

  // shadow copy of the list
  logic signed [DATA_W-1:0]  list_vals [CAPACITY_DEF];
  int                        list_len = 0;

  list_result_t              pending_results [$];
  list_result_t              pin_res = '0;
  bit                        pin_on = 1'b0;
  list_result_t              want_res;
  bit                        in_took = 1'b0;
  int                        stall_cycles = 0;
  int                        failures = 0;
  int                        gap_pct = 34;

  dir_row_t dir_table [DIR_ROWS] = '{
    '{1'b0, CMD_READ,   6'd0,  32'h0000_0000, 1'b1, ST_RANGE, 7'd0,  32'h0000_0000},
    '{1'b0, CMD_DELETE, 6'd63, 32'h0000_0000, 1'b1, ST_RANGE, 7'd0,  32'h0000_0000},
    // empty list: position ignored, value appended
    '{1'b0, CMD_INSERT, 6'd63, 32'h7FFF_FFFF, 1'b1, ST_OK,    7'd1,  32'h0000_0000},
    '{1'b0, CMD_INSERT, 6'd0,  32'h8000_0000, 1'b1, ST_OK,    7'd2,  32'h0000_0000},
    '{1'b0, CMD_INSERT, 6'd0,  32'h0000_0000, 1'b1, ST_OK,    7'd3,  32'h0000_0000},
    '{1'b0, CMD_INSERT, 6'd5,  32'h0000_0001, 1'b1, ST_RANGE, 7'd3,  32'h0000_0000},
    '{1'b0, CMD_READ,   6'd0,  32'h0000_0000, 1'b1, ST_OK,    7'd3,  32'h7FFF_FFFF},
    '{1'b0, CMD_READ,   6'd1,  32'h0000_0000, 1'b0, ST_OK,    7'd0,  32'h0000_0000},
    '{1'b0, CMD_READ,   6'd2,  32'h0000_0000, 1'b1, ST_OK,    7'd3,  32'h8000_0000},
    '{1'b0, CMD_READ,   6'd3,  32'h0000_0000, 1'b1, ST_RANGE, 7'd3,  32'h0000_0000},
    '{1'b0, CMD_NOP,    6'd63, 32'hFFFF_FFFF, 1'b1, ST_OK,    7'd3,  32'h0000_0000},
    '{1'b0, CMD_DELETE, 6'd1,  32'h0000_0000, 1'b1, ST_OK,    7'd2,  32'h0000_0000},
    '{1'b0, CMD_READ,   6'd1,  32'h0000_0000, 1'b0, ST_OK,    7'd0,  32'h0000_0000},
    '{1'b0, CMD_DELETE, 6'd2,  32'h0000_0000, 1'b1, ST_RANGE, 7'd2,  32'h0000_0000},
    '{1'b0, CMD_DELETE, 6'd0,  32'h0000_0000, 1'b1, ST_OK,    7'd1,  32'h0000_0000},
    '{1'b0, CMD_DELETE, 6'd0,  32'h0000_0000, 1'b1, ST_OK,    7'd0,  32'h0000_0000},
    '{1'b0, CMD_INSERT, 6'd42, 32'hAAAA_AAAA, 1'b1, ST_OK,    7'd1,  32'h0000_0000},
    '{1'b1, CMD_INSERT, 6'd0,  32'h5555_5555, 1'b1, ST_FULL,  7'd64, 32'h0000_0000},
    '{1'b0, CMD_INSERT, 6'd63, 32'h1234_5678, 1'b1, ST_FULL,  7'd64, 32'h0000_0000},
    '{1'b0, CMD_READ,   6'd63, 32'h0000_0000, 1'b0, ST_OK,    7'd0,  32'h0000_0000},
    '{1'b0, CMD_DELETE, 6'd63, 32'h0000_0000, 1'b1, ST_OK,    7'd63, 32'h0000_0000},
    // one past the last element is out of range even with room left
    '{1'b0, CMD_INSERT, 6'd63, 32'h0F0F_0F0F, 1'b1, ST_RANGE, 7'd63, 32'h0000_0000},
    '{1'b0, CMD_INSERT, 6'd62, 32'hDEAD_BEEF, 1'b1, ST_OK,    7'd64, 32'h0000_0000},
    '{1'b0, CMD_READ,   6'd0,  32'h0000_0000, 1'b0, ST_OK,    7'd0,  32'h0000_0000},
    '{1'b0, CMD_DELETE, 6'd0,  32'h0000_0000, 1'b1, ST_OK,    7'd63, 32'h0000_0000},
    '{1'b0, CMD_NOP,    6'd0,  32'h0000_0000, 1'b0, ST_OK,    7'd0,  32'h0000_0000}
  };

  positional_list_insert_delete_top #(
    .CAPACITY(CAPACITY_DEF)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_position   (in_position),
    .in_new_value  (in_new_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_length    (out_length),
    .out_read_value(out_read_value)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void place_value(int slot, logic signed [DATA_W-1:0] v);
    for (int i = list_len; i > slot; i--) list_vals[i] = list_vals[i-1];
    list_vals[slot] = v;
    list_len++;
  endfunction

  function automatic list_result_t apply_list_op(plid_cmd_t cmd, logic [POS_W-1:0] pos,
                                                 logic signed [DATA_W-1:0] val);
    list_result_t r;
    int           p;
    bit           append;
    r = '0;
    r.status = ST_OK;
    p = int'(pos);
    case (cmd)
      CMD_INSERT: begin
        append = (list_len == 0) || (p + 1 == list_len);
        if (append) begin
          if (list_len >= CAPACITY_DEF) r.status = ST_FULL;
          else place_value(list_len, val);
        end else if (p >= list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= CAPACITY_DEF) begin
          r.status = ST_FULL;
        end else begin
          place_value(p + 1, val);
        end
      end
      CMD_DELETE: begin
        if (p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = p; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      CMD_READ: begin
        if (p >= list_len) r.status = ST_RANGE;
        else r.read_value = list_vals[p];
      end
      default: ;
    endcase
    r.length = LEN_W'(list_len);
    return r;
  endfunction

  // Sample both channels, predict, check, watchdog.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_took = 1'b0;
      stall_cycles = 0;
    end else begin
      in_took = in_valid && in_ready;
      if (in_took) begin
        want_res = apply_list_op(plid_cmd_t'(in_command), in_position, in_new_value);
        if (pin_on) want_res = pin_res;
        pending_results.push_back(want_res);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          failures++;
          $error("result with no request pending: status %0d length %0d read_value %0d",
                 out_status, out_length, out_read_value);
        end else begin
          want_res = pending_results.pop_front();
          if (out_status !== want_res.status) begin
            failures++;
            $error("status: expected %0d, got %0d", want_res.status, out_status);
          end
          if (out_length !== want_res.length) begin
            failures++;
            $error("length: expected %0d, got %0d", want_res.length, out_length);
          end
          if (out_read_value !== want_res.read_value) begin
            failures++;
            $error("read_value: expected %0d, got %0d", want_res.read_value, out_read_value);
          end
        end
      end
      if (in_took || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("positional_list_insert_delete_top_tb failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= gap_pct);
  end

  // Returns at the falling edge after the request was taken.
  task automatic send_request(input plid_cmd_t cmd, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val, input bit pinned,
                              input list_result_t pin);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_command   = cmd;
    in_position  = pos;
    in_new_value = val;
    pin_on       = pinned;
    pin_res      = pin;
    in_valid     = 1'b1;
    do @(negedge clk); while (!in_took);
  endtask

  initial begin
    plid_cmd_t                cmd;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    int                       pick;
    bit                       grow;
    list_result_t             pin;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_table[k]) begin
      if (dir_table[k].fill) begin
        while (list_len < CAPACITY_DEF)
          send_request(CMD_INSERT, POS_W'($urandom_range(list_len - 1)), $urandom, 1'b0, '0);
      end
      pin = '{dir_table[k].st, dir_table[k].len, dir_table[k].rd};
      send_request(dir_table[k].cmd, dir_table[k].pos, dir_table[k].val,
                   dir_table[k].pinned, pin);
    end

    for (int blk = 0; blk < RAND_BLOCKS; blk++) begin
      grow = (blk % 2 == 0);
      gap_pct = (blk == 2) ? 0 : 34;
      if (blk == 4) begin
        // hold off until every outstanding request has returned
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < (grow ? 55 : 25)) cmd = CMD_INSERT;
        else if (pick < (grow ? 75 : 65)) cmd = CMD_DELETE;
        else if (pick < 95) cmd = CMD_READ;
        else cmd = CMD_NOP;

        pick = $urandom_range(9);
        if (pick == 0 || list_len == 0) pos = POS_W'($urandom_range(63));
        else if (cmd == CMD_INSERT && pick < 4) pos = POS_W'(list_len - 1);
        else pos = POS_W'($urandom_range(list_len - 1));

        val = $urandom;
        if ($urandom_range(15) == 0) begin
          case ($urandom_range(3))
            0: val = 32'h8000_0000;
            1: val = 32'h7FFF_FFFF;
            2: val = 32'h0000_0000;
            default: val = 32'hFFFF_FFFF;
          endcase
        end
        send_request(cmd, pos, val, 1'b0, '0);
      end
    end

    in_valid = 1'b0;
    gap_pct = 34;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    if (failures == 0) begin
      $display("positional_list_insert_delete_top_tb passed");
    end else begin
      $display("positional_list_insert_delete_top_tb failed");
    end
    $finish;
  end

endmodule
